FILE: rtl/core/qkvlf_pkg.sv
// ----------------------------------------------------------------------------
// qkvlf_pkg: shared types and constants of the quoted key/value line finder
// Holds the sizes, the register map codes and the structs that travel
// between the front classifier, the item queue and the back parser.
// ----------------------------------------------------------------------------
package qkvlf_pkg;

  localparam int KEY_BYTES     = 32;
  localparam int KEY_WORDS     = 4;
  localparam int VALUE_BYTES   = 512;
  localparam int WS_SLOTS      = 8;
  localparam int COMMENT_BYTES = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam int KPOS_W = 6;
  localparam int VCNT_W = $clog2(VALUE_BYTES);
  localparam int CPOS_W = 3;

  localparam logic [7:0] NEWLINE = 8'd10;

  // Register map
  typedef enum logic [2:0] {
    CFG_WS_SET   = 3'd0,
    CFG_DELIM    = 3'd1,
    CFG_KEY_LEN  = 3'd2,
    CFG_KEY_W0   = 3'd3,
    CFG_KEY_W1   = 3'd4,
    CFG_KEY_W2   = 3'd5,
    CFG_KEY_W3   = 3'd6
  } cfg_idx_e;

  localparam logic [63:0] WS_SET_RST = 64'd729097;
  localparam logic [55:0] DELIM_RST  = 56'd587278141;

  typedef struct packed {
    logic [63:0]                ws_set;
    logic [55:0]                delim;
    logic [KPOS_W-1:0]          key_len;
    logic [KEY_WORDS-1:0][63:0] key_words;
  } cfg_t;

  // Classified input byte
  typedef struct packed {
    logic [7:0] char_code;
    logic       eos;
    logic       is_nl;
    logic       is_ws;
    logic       is_sep;
    logic       is_wrap;
  } item_t;

  // One result
  typedef struct packed {
    logic       value_valid;
    logic [7:0] value_byte;
    logic       line_end;
    logic       line_match;
    logic       value_truncated;
    logic       stream_end;
    logic       stream_found;
  } result_t;

endpackage

FILE: rtl/core/qkvlf_front.sv
// ----------------------------------------------------------------------------
// qkvlf_front: input acceptance and byte classification
// Flags newline, whitespace, separator and wrapper for each accepted byte
// and pushes the classified transaction into the queue.
// ----------------------------------------------------------------------------
module qkvlf_front import qkvlf_pkg::*; (
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] char_code_i,
  input  logic       eos_i,
  input  cfg_t       cfg_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output item_t      item_o
);

  logic ws_hit;

  always_comb begin
    ws_hit = 1'b0;
    for (int s = 0; s < WS_SLOTS; s++) begin
      if (cfg_i.ws_set[8*s +: 8] != 8'd0 && cfg_i.ws_set[8*s +: 8] == char_code_i) begin
        ws_hit = 1'b1;
      end
    end
  end

  assign s_tready_o = !queue_full_i;
  assign push_o     = s_tvalid_i && !queue_full_i;

  assign item_o.char_code = char_code_i;
  assign item_o.eos       = eos_i;
  assign item_o.is_nl     = (char_code_i == NEWLINE);
  assign item_o.is_ws     = ws_hit;
  assign item_o.is_sep    = (char_code_i == cfg_i.delim[7:0]);
  assign item_o.is_wrap   = (char_code_i == cfg_i.delim[15:8]);

endmodule

FILE: rtl/core/qkvlf_queue.sv
// ----------------------------------------------------------------------------
// qkvlf_queue: short queue of classified bytes
// Decouples the front classifier from the back parser.
// ----------------------------------------------------------------------------
module qkvlf_queue import qkvlf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_push_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
`endif

endmodule

FILE: rtl/core/qkvlf_back.sv
// ----------------------------------------------------------------------------
// qkvlf_back: line parser and result register
// Runs the per-line parse state machine on classified bytes and holds the
// result in an output register toward the master side.
// ----------------------------------------------------------------------------
module qkvlf_back import qkvlf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    m_tvalid_o,
  input  logic    m_tready_i,
  output result_t result_o
);

  localparam logic [2:0] PH_LEAD      = 3'd0;
  localparam logic [2:0] PH_KEY       = 3'd1;
  localparam logic [2:0] PH_KEY_WS    = 3'd2;
  localparam logic [2:0] PH_AFTER_SEP = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;
  localparam logic [2:0] PH_TAIL      = 3'd5;
  localparam logic [2:0] PH_REJECT    = 3'd6;

  logic [2:0]        phase_q, phase_d;
  logic [KPOS_W-1:0] kpos_q, kpos_d;
  logic              kalive_q, kalive_d;
  logic [CPOS_W-1:0] cpos_q, cpos_d;
  logic              calive_q, calive_d;
  logic [VCNT_W-1:0] vcnt_q, vcnt_d;
  logic              found_q, found_d;
  logic              trunc_q, trunc_d;
  logic              out_valid_q;
  result_t           out_q, res;

  logic [7:0]        key_byte;
  logic [7:0]        cmt_byte;
  logic [CPOS_W-1:0] clen_raw, clen, cpos_next;
  logic              key_done, feed_ok, ws;

  assign pop_o = item_valid_i && (!out_valid_q || m_tready_i);

  assign key_byte = (kpos_q < KPOS_W'(KEY_BYTES))
                  ? cfg_i.key_words[kpos_q[4:3]][8*kpos_q[2:0] +: 8] : 8'd0;
  assign cmt_byte = (cpos_q < CPOS_W'(COMMENT_BYTES))
                  ? cfg_i.delim[24 + 8*cpos_q[1:0] +: 8] : 8'd0;
  assign clen_raw = cfg_i.delim[18:16];
  assign clen     = (clen_raw > CPOS_W'(COMMENT_BYTES)) ? CPOS_W'(COMMENT_BYTES) : clen_raw;
  assign cpos_next = cpos_q + 1'b1;
  assign key_done = kalive_q && (cfg_i.key_len <= KPOS_W'(KEY_BYTES))
                 && (kpos_q == cfg_i.key_len);
  assign feed_ok  = kalive_q && (kpos_q < cfg_i.key_len)
                 && (kpos_q < KPOS_W'(KEY_BYTES)) && (item_i.char_code == key_byte);
  assign ws       = item_i.is_ws;

  always_comb begin
    phase_d  = phase_q;
    kpos_d   = kpos_q;
    kalive_d = kalive_q;
    cpos_d   = cpos_q;
    calive_d = calive_q;
    vcnt_d   = vcnt_q;
    found_d  = found_q;
    trunc_d  = trunc_q;
    res      = '0;

    if (!found_q) begin
      if (item_i.is_nl) begin
        res.line_end = 1'b1;
        if (phase_q == PH_TAIL) begin
          res.line_match      = 1'b1;
          res.value_truncated = trunc_q;
          found_d             = 1'b1;
        end
        phase_d  = PH_LEAD;
        kpos_d   = '0;
        kalive_d = 1'b1;
        cpos_d   = '0;
        calive_d = 1'b1;
        vcnt_d   = '0;
        trunc_d  = 1'b0;
      end else begin
        case (phase_q)
          PH_LEAD: begin
            if (!ws) begin
              if (item_i.is_sep) begin
                phase_d = key_done ? PH_AFTER_SEP : PH_REJECT;
              end else begin
                if (feed_ok) kpos_d = kpos_q + 1'b1;
                else         kalive_d = 1'b0;
                phase_d = PH_KEY;
              end
            end
          end
          PH_KEY: begin
            if (item_i.is_sep) begin
              phase_d = key_done ? PH_AFTER_SEP : PH_REJECT;
            end else if (ws) begin
              phase_d = key_done ? PH_KEY_WS : PH_REJECT;
            end else if (feed_ok) begin
              kpos_d = kpos_q + 1'b1;
            end else begin
              kalive_d = 1'b0;
            end
          end
          PH_KEY_WS: begin
            if (item_i.is_sep) phase_d = PH_AFTER_SEP;
            else if (!ws)      phase_d = PH_REJECT;
          end
          PH_AFTER_SEP: begin
            if (item_i.is_wrap) phase_d = PH_VALUE;
            else if (!ws)       phase_d = PH_REJECT;
          end
          PH_VALUE: begin
            if (item_i.is_wrap) begin
              phase_d = PH_TAIL;
            end else if (vcnt_q < VCNT_W'(VALUE_BYTES - 1)) begin
              res.value_valid = 1'b1;
              res.value_byte  = item_i.char_code;
              vcnt_d          = vcnt_q + 1'b1;
            end else begin
              trunc_d = 1'b1;
            end
          end
          PH_TAIL: begin
            if (!ws) phase_d = PH_REJECT;
          end
          default: phase_d = PH_REJECT;
        endcase

        // comment prefix tracking from the first non-whitespace byte on
        if (phase_q != PH_REJECT && (phase_q != PH_LEAD || !ws)
            && clen != '0 && calive_q) begin
          if (cpos_q < clen && item_i.char_code == cmt_byte) begin
            cpos_d = cpos_next;
            if (cpos_next == clen) begin
              calive_d = 1'b0;
              phase_d  = PH_REJECT;
            end
          end else begin
            calive_d = 1'b0;
          end
        end
      end
    end

    if (item_i.eos) begin
      res.stream_end   = 1'b1;
      res.stream_found = found_d;
      phase_d  = PH_LEAD;
      kpos_d   = '0;
      kalive_d = 1'b1;
      cpos_d   = '0;
      calive_d = 1'b1;
      vcnt_d   = '0;
      trunc_d  = 1'b0;
      found_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      kpos_q      <= '0;
      kalive_q    <= 1'b1;
      cpos_q      <= '0;
      calive_q    <= 1'b1;
      vcnt_q      <= '0;
      found_q     <= 1'b0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        kpos_q      <= kpos_d;
        kalive_q    <= kalive_d;
        cpos_q      <= cpos_d;
        calive_q    <= calive_d;
        vcnt_q      <= vcnt_d;
        found_q     <= found_d;
        trunc_q     <= trunc_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign result_o   = out_q;

`ifndef NO_ASSERTIONS
  a_match_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.line_match) |-> out_q.line_end)
    else $error("match without line end");

  a_trunc_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.value_truncated) |-> out_q.line_match)
    else $error("truncation flag without match");

  a_found_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.stream_found) |-> out_q.stream_end)
    else $error("found flag without stream end");

  a_match_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res.line_match && !item_i.eos) |=> found_q)
    else $error("match did not latch found flag");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_REJECT)
    else $error("parse phase out of range");
`endif

endmodule

FILE: rtl/core/quoted_key_value_line_finder_core.sv
// ----------------------------------------------------------------------------
// quoted_key_value_line_finder_core: finds the first quoted key/value line
// Scans a byte stream for the first line ws* KEY ws* SEP ws* WRAP value WRAP
// ws* newline whose key equals the configured key, streaming value bytes
// tentatively and confirming them with a verdict at the newline.
//
//  channel   | direction | handshake       | payload
//  ----------+-----------+-----------------+----------------------------------
//  s_axis    | in        | tvalid / tready | tdata char_code, tlast end_of_stream
//  m_axis    | out       | tvalid / tready | tdata flags + value byte, tlast
//  cfg       | in        | cfg_we_i        | cfg_idx_i register, cfg_wdata_i
//
// Throughput is one transaction per cycle while the sink takes each result;
// each byte needs only parallel compares and one update of the line parser
// state. Each byte is registered in the queue after the classifier, and its
// result in the output register after the parser.
// The two-entry queue lets input acceptance continue while the output
// register holds a result the sink has not taken yet.
// Reset clears all parser state; configuration registers return to their
// defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module quoted_key_value_line_finder_core import qkvlf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] value_valid, [8:1] value_byte, [9] line_end, [10] line_match,
  // [11] value_truncated, [12] stream_found, [15:13] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,   // stream_end
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  item_t   front_item, queue_item;
  logic    push, pop, queue_full, queue_valid;
  result_t result;

  // Configuration registers; user writes only while block is idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ws_set    <= WS_SET_RST;
      cfg_q.delim     <= DELIM_RST;
      cfg_q.key_len   <= '0;
      cfg_q.key_words <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WS_SET:  cfg_q.ws_set       <= cfg_wdata_i;
        CFG_DELIM:   cfg_q.delim        <= cfg_wdata_i[55:0];
        CFG_KEY_LEN: cfg_q.key_len      <= cfg_wdata_i[KPOS_W-1:0];
        CFG_KEY_W0:  cfg_q.key_words[0] <= cfg_wdata_i;
        CFG_KEY_W1:  cfg_q.key_words[1] <= cfg_wdata_i;
        CFG_KEY_W2:  cfg_q.key_words[2] <= cfg_wdata_i;
        CFG_KEY_W3:  cfg_q.key_words[3] <= cfg_wdata_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Front: accept and classify
  qkvlf_front u_front (
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .char_code_i  (s_axis_tdata),
    .eos_i        (s_axis_tlast),
    .cfg_i        (cfg_q),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  // Queue between classifier and parser
  qkvlf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .item_o  (queue_item)
  );

  // Back: line parser and output register
  qkvlf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {3'b000, result.stream_found, result.value_truncated,
                         result.line_match, result.line_end, result.value_byte,
                         result.value_valid};
  assign m_axis_tlast = result.stream_end;

endmodule
